// ===== design/mtwq_pkg.sv =====
// Shared types, sizes and helper functions for the mutex table block.
// No dependencies; every other file but mtwq_ram imports this package.
`timescale 1ns / 1ps

package mtwq_pkg;

    // sizing
    localparam int NUM_MUTEXES = 16;
    localparam int WAIT_DEPTH  = 16;
    localparam int PID_BITS    = 8;

    // fixed field widths of the ports
    localparam int OP_W   = 2;
    localparam int ID_W   = 4;
    localparam int PID_W  = 8;
    localparam int ST_W   = 2;
    localparam int LCNT_W = 5;

    // derived widths
    localparam int MIDX_W  = $clog2(NUM_MUTEXES);
    localparam int FCNT_W  = $clog2(NUM_MUTEXES + 1);
    localparam int WHEAD_W = $clog2(WAIT_DEPTH);
    localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int HCNT_W  = $clog2(WAIT_DEPTH + 2);
    localparam int QDEPTH  = NUM_MUTEXES * WAIT_DEPTH;
    localparam int QADDR_W = $clog2(QDEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_DESTROY = 2'd1,
        OP_LOCK    = 2'd2,
        OP_UNLOCK  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_ERROR   = 2'd2
    } st_t;

    // per-mutex bookkeeping
    typedef struct packed {
        logic                alloc;
        logic [HCNT_W-1:0]   hold;
        logic                owner_valid;
        logic [PID_BITS-1:0] owner_pid;
        logic [WHEAD_W-1:0]  whead;
        logic [WCNT_W-1:0]   wcnt;
    } mutex_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // item accepted this edge
        logic exec;   // execute cycle
    } ctrl_cmd_t;

    function automatic logic [MIDX_W-1:0] mutex_idx(input logic [ID_W-1:0] id);
        return MIDX_W'(id);
    endfunction

    // (head + count) mod WAIT_DEPTH, sum stays below twice the depth
    function automatic logic [WHEAD_W-1:0] wait_slot(input logic [WHEAD_W-1:0] head,
                                                     input logic [WCNT_W-1:0]  cnt);
        logic [WCNT_W:0] sum;
        sum = (WCNT_W + 1)'(head) + (WCNT_W + 1)'(cnt);
        if (sum >= (WCNT_W + 1)'(WAIT_DEPTH))
        begin
            sum = sum - (WCNT_W + 1)'(WAIT_DEPTH);
        end
        return WHEAD_W'(sum);
    endfunction

    function automatic logic [QADDR_W-1:0] queue_addr(input logic [MIDX_W-1:0]  idx,
                                                      input logic [WHEAD_W-1:0] slot);
        return QADDR_W'(QADDR_W'(idx) * QADDR_W'(WAIT_DEPTH) + QADDR_W'(slot));
    endfunction

    // (head + count) mod NUM_MUTEXES for the free id FIFO
    function automatic logic [MIDX_W-1:0] free_slot(input logic [MIDX_W-1:0] head,
                                                    input logic [FCNT_W-1:0] cnt);
        logic [FCNT_W:0] sum;
        sum = (FCNT_W + 1)'(head) + (FCNT_W + 1)'(cnt);
        if (sum >= (FCNT_W + 1)'(NUM_MUTEXES))
        begin
            sum = sum - (FCNT_W + 1)'(NUM_MUTEXES);
        end
        return MIDX_W'(sum);
    endfunction

endpackage

// ===== design/mtwq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mtwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mtwq_ctrl.sv =====
// Sequencer for the mutex table: accept, execute, result strobe.
// Depends on mtwq_pkg.
`timescale 1ns / 1ps

module mtwq_ctrl
    import mtwq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output ctrl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = 1'b0;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                    busy_next  = 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign cmd.load = start && !busy_reg;
    assign cmd.exec = busy_reg;

    // execute lasts exactly one cycle and is followed by the strobe
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (!busy_reg && done_reg))
        else $error("execute cycle not followed by result strobe");

    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg == S_EXEC))
        else $error("busy out of step with state");

endmodule

// ===== design/mtwq_datapath.sv =====
// Mutex tables, free id FIFO, wait queue RAM and result registers.
// Depends on mtwq_pkg and mtwq_ram.
`timescale 1ns / 1ps

module mtwq_datapath
    import mtwq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [OP_W-1:0]   opcode,
    input  logic [ID_W-1:0]   mutex_id,
    input  logic [PID_W-1:0]  caller_pid,
    output logic [ST_W-1:0]   status,
    output logic [ID_W-1:0]   result_id,
    output logic [LCNT_W-1:0] lock_count,
    output logic              wake_valid,
    output logic [PID_W-1:0]  wake_pid
);

    // captured item
    op_t                 op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PID_BITS-1:0] pid_reg;

    // state
    mutex_entry_t      tbl_reg [NUM_MUTEXES];
    logic [MIDX_W-1:0] fifo_reg [NUM_MUTEXES];
    logic [MIDX_W-1:0] fhead_reg, fhead_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;

    // results
    st_t                 st_reg, st_next;
    logic [ID_W-1:0]     rid_reg, rid_next;
    logic [LCNT_W-1:0]   cnt_reg, cnt_next;
    logic                wv_reg, wv_next;
    logic [PID_BITS-1:0] wp_reg, wp_next;

    // execute-cycle signals
    logic [MIDX_W-1:0]   tidx;
    mutex_entry_t        ent;
    mutex_entry_t        ent_new;
    logic                ent_we;
    logic                fifo_we;
    logic [MIDX_W-1:0]   fifo_waddr;
    logic                id_ok;

    // wait queue RAM
    logic                q_we;
    logic [QADDR_W-1:0]  q_waddr;
    logic [QADDR_W-1:0]  q_raddr;
    logic [PID_BITS-1:0] q_rdata;

    // head entry of the target queue is fetched on accept
    assign q_raddr = queue_addr(mutex_idx(mutex_id), tbl_reg[mutex_idx(mutex_id)].whead);

    mtwq_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (QDEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (pid_reg),
        .re    (cmd.load),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(opcode);
            id_reg  <= mutex_id;
            pid_reg <= PID_BITS'(caller_pid);
        end
    end

    assign tidx  = (op_reg == OP_ALLOC) ? fifo_reg[fhead_reg] : mutex_idx(id_reg);
    assign ent   = tbl_reg[tidx];
    assign id_ok = (32'(id_reg) < 32'(NUM_MUTEXES)) && ent.alloc;

    always_comb
    begin
        st_next    = ST_DONE;
        rid_next   = id_reg;
        cnt_next   = '0;
        wv_next    = 1'b0;
        wp_next    = '0;
        ent_new    = ent;
        ent_we     = 1'b0;
        fifo_we    = 1'b0;
        fifo_waddr = free_slot(fhead_reg, fcnt_reg);
        fhead_next = fhead_reg;
        fcnt_next  = fcnt_reg;
        q_we       = 1'b0;
        q_waddr    = queue_addr(tidx, wait_slot(ent.whead, ent.wcnt));

        if (op_reg == OP_ALLOC)
        begin
            if (fcnt_reg == '0)
            begin
                st_next  = ST_ERROR;
                rid_next = '0;
            end
            else
            begin
                fhead_next    = (32'(fhead_reg) == NUM_MUTEXES - 1) ? '0
                                : MIDX_W'(fhead_reg + 1'b1);
                fcnt_next     = FCNT_W'(fcnt_reg - 1'b1);
                ent_new       = '0;
                ent_new.alloc = 1'b1;
                ent_we        = 1'b1;
                rid_next      = ID_W'(tidx);
            end
        end
        else if (!id_ok)
        begin
            st_next = ST_ERROR;
        end
        else
        begin
            unique case (op_reg)
                OP_DESTROY:
                begin
                    if (ent.hold != '0)
                    begin
                        st_next  = ST_ERROR;
                        cnt_next = LCNT_W'(ent.hold);
                    end
                    else
                    begin
                        if (32'(fcnt_reg) < NUM_MUTEXES)
                        begin
                            fifo_we   = 1'b1;
                            fcnt_next = FCNT_W'(fcnt_reg + 1'b1);
                        end
                        ent_new = '0;
                        ent_we  = 1'b1;
                    end
                end
                OP_LOCK:
                begin
                    if (ent.hold == '0)
                    begin
                        ent_new.owner_valid = 1'b1;
                        ent_new.owner_pid   = pid_reg;
                        ent_new.hold        = HCNT_W'(1);
                        ent_we              = 1'b1;
                        cnt_next            = LCNT_W'(1);
                    end
                    else if (32'(ent.wcnt) >= WAIT_DEPTH)
                    begin
                        st_next  = ST_ERROR;
                        cnt_next = LCNT_W'(ent.hold);
                    end
                    else
                    begin
                        q_we         = 1'b1;
                        ent_new.wcnt = WCNT_W'(ent.wcnt + 1'b1);
                        ent_new.hold = HCNT_W'(ent.hold + 1'b1);
                        ent_we       = 1'b1;
                        st_next      = ST_BLOCKED;
                        cnt_next     = LCNT_W'(ent_new.hold);
                    end
                end
                OP_UNLOCK:
                begin
                    if (ent.hold == '0)
                    begin
                        cnt_next = '0;
                    end
                    else if (!ent.owner_valid || ent.owner_pid != pid_reg)
                    begin
                        st_next  = ST_ERROR;
                        cnt_next = LCNT_W'(ent.hold);
                    end
                    else
                    begin
                        ent_new.hold = HCNT_W'(ent.hold - 1'b1);
                        ent_we       = 1'b1;
                        if (ent.wcnt != '0)
                        begin
                            ent_new.whead       = wait_slot(ent.whead, WCNT_W'(1));
                            ent_new.wcnt        = WCNT_W'(ent.wcnt - 1'b1);
                            ent_new.owner_pid   = q_rdata;
                            ent_new.owner_valid = 1'b1;
                            wv_next             = 1'b1;
                            wp_next             = q_rdata;
                        end
                        else
                        begin
                            ent_new.owner_valid = 1'b0;
                            ent_new.owner_pid   = '0;
                        end
                        cnt_next = LCNT_W'(ent_new.hold);
                    end
                end
                default:
                begin
                    st_next = ST_ERROR;
                end
            endcase
        end

        // only the execute cycle commits anything
        if (!cmd.exec)
        begin
            ent_we     = 1'b0;
            fifo_we    = 1'b0;
            q_we       = 1'b0;
            fhead_next = fhead_reg;
            fcnt_next  = fcnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MUTEXES; i++)
            begin
                tbl_reg[i]  <= '0;
                fifo_reg[i] <= MIDX_W'(i);
            end
            fhead_reg <= '0;
            fcnt_reg  <= FCNT_W'(NUM_MUTEXES);
            st_reg    <= ST_DONE;
            rid_reg   <= '0;
            cnt_reg   <= '0;
            wv_reg    <= 1'b0;
            wp_reg    <= '0;
        end
        else
        begin
            if (ent_we)
            begin
                tbl_reg[tidx] <= ent_new;
            end
            if (fifo_we)
            begin
                fifo_reg[fifo_waddr] <= tidx;
            end
            fhead_reg <= fhead_next;
            fcnt_reg  <= fcnt_next;
            if (cmd.exec)
            begin
                st_reg  <= st_next;
                rid_reg <= rid_next;
                cnt_reg <= cnt_next;
                wv_reg  <= wv_next;
                wp_reg  <= wp_next;
            end
        end
    end

    assign status     = st_reg;
    assign result_id  = rid_reg;
    assign lock_count = cnt_reg;
    assign wake_valid = wv_reg;
    assign wake_pid   = PID_W'(wp_reg);

    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fcnt_reg) <= NUM_MUTEXES)
        else $error("free id count above table size");

    a_wake_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        wv_reg |-> (st_reg == ST_DONE))
        else $error("hand-over reported with non-done status");

    a_queue_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
        q_we |-> (cmd.exec && op_reg == OP_LOCK))
        else $error("wait queue written outside a lock execute");

endmodule

// ===== design/mutex_table_with_wait_queues_core.sv =====
// Top level of the hardware mutex unit with FIFO wait queues.
// Depends on mtwq_pkg, mtwq_ctrl, mtwq_datapath (which holds mtwq_ram).
`timescale 1ns / 1ps

// Each item passes an accept step and an execute step: the accept edge
// (start high, busy low) captures the command and fetches the head entry
// of the target mutex's wait queue from the queue RAM; the next cycle,
// with busy high, does the read-modify-write of that mutex's count, owner
// and queue pointers and registers the result. The result then sits on
// the result ports for one cycle with done high, and that same cycle
// already accepts the next item; no new item is taken while the last one
// executes, since its update waits on the registered read of the queue
// RAM. The receiver cannot stall: a result that is not taken in its done
// cycle is gone. Every item yields exactly one result. After reset the
// free id FIFO holds all ids in order and no mutex is allocated; the queue
// RAM needs no clearing because only pushed entries are ever popped.

module mutex_table_with_wait_queues_core
    import mtwq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // command side
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   opcode,
    input  logic [ID_W-1:0]   mutex_id,
    input  logic [PID_W-1:0]  caller_pid,
    // result side, one-cycle strobe
    output logic              done,
    output logic [ST_W-1:0]   status,
    output logic [ID_W-1:0]   result_id,
    output logic [LCNT_W-1:0] lock_count,
    output logic              wake_valid,
    output logic [PID_W-1:0]  wake_pid
);

    ctrl_cmd_t cmd;

    // sequencing: idle / execute, plus the result strobe
    mtwq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // tables, free id FIFO, queue RAM, result registers
    mtwq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (opcode),
        .mutex_id   (mutex_id),
        .caller_pid (caller_pid),
        .status     (status),
        .result_id  (result_id),
        .lock_count (lock_count),
        .wake_valid (wake_valid),
        .wake_pid   (wake_pid)
    );

endmodule

// ===== tb/sv/mutex_table_with_wait_queues_core_tb.sv =====
// Self-checking testbench for mutex_table_with_wait_queues_core.
// Depends on mtwq_pkg and the block's RTL; holds its own model of the mutex table.
`timescale 1ns / 1ps

module mutex_table_with_wait_queues_core_tb;
    import mtwq_pkg::*;

    // quiet cycles (nothing accepted, no result) before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // idle cycles after the last result, before the verdict
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        st_t               status;
        logic [ID_W-1:0]   result_id;
        logic [LCNT_W-1:0] lock_count;
        logic              wake_valid;
        logic [PID_W-1:0]  wake_pid;
    } mutex_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   opcode = '0;
    logic [ID_W-1:0]   mutex_id = '0;
    logic [PID_W-1:0]  caller_pid = '0;
    logic              done;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   result_id;
    logic [LCNT_W-1:0] lock_count;
    logic              wake_valid;
    logic [PID_W-1:0]  wake_pid;

    mutex_reply_t      pending_replies[$];
    mutex_reply_t      oldest_reply;
    int                mismatch_count = 0;
    int                quiet_cycles = 0;
    int                idle_pct = 0;

    // model state of the mutex table
    int                free_ids [NUM_MUTEXES];
    int                free_head;
    int                free_cnt;
    bit                is_alloc [NUM_MUTEXES];
    int                hold_cnt [NUM_MUTEXES];
    bit                has_owner [NUM_MUTEXES];
    logic [PID_W-1:0]  owner_of [NUM_MUTEXES];
    logic [PID_W-1:0]  waiters [NUM_MUTEXES][WAIT_DEPTH];
    int                wait_head [NUM_MUTEXES];
    int                wait_cnt [NUM_MUTEXES];

    always #5 clk = ~clk;

    mutex_table_with_wait_queues_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .mutex_id   (mutex_id),
        .caller_pid (caller_pid),
        .done       (done),
        .status     (status),
        .result_id  (result_id),
        .lock_count (lock_count),
        .wake_valid (wake_valid),
        .wake_pid   (wake_pid)
    );

    // ------------------------------------------------------------------
    // Mutex table model
    // ------------------------------------------------------------------

    function automatic void clear_entry(int m);
        is_alloc[m]  = 1'b0;
        hold_cnt[m]  = 0;
        has_owner[m] = 1'b0;
        owner_of[m]  = '0;
        wait_head[m] = 0;
        wait_cnt[m]  = 0;
    endfunction

    function automatic void reset_table();
        int i;
        for (i = 0; i < NUM_MUTEXES; i++)
        begin
            free_ids[i] = i;
            clear_entry(i);
        end
        free_head = 0;
        free_cnt  = NUM_MUTEXES;
    endfunction

    // Applies one command to the model and returns the reply it must produce.
    function automatic mutex_reply_t apply_mutex_op(op_t op, logic [ID_W-1:0] id,
                                                    logic [PID_W-1:0] pid_in);
        mutex_reply_t     r;
        int               m;
        int               slot;
        logic [PID_W-1:0] pid;
        pid          = pid_in & PID_W'((1 << PID_BITS) - 1);
        m            = int'(id);
        r.status     = ST_DONE;
        r.result_id  = id;
        r.lock_count = '0;
        r.wake_valid = 1'b0;
        r.wake_pid   = '0;
        if (op == OP_ALLOC)
        begin
            if (free_cnt == 0)
            begin
                r.status    = ST_ERROR;
                r.result_id = '0;
            end
            else
            begin
                m         = free_ids[free_head];
                free_head = (free_head + 1) % NUM_MUTEXES;
                free_cnt--;
                clear_entry(m);
                is_alloc[m] = 1'b1;
                r.result_id = ID_W'(m);
            end
        end
        else if (m >= NUM_MUTEXES || !is_alloc[m])
        begin
            r.status = ST_ERROR;
        end
        else if (op == OP_DESTROY)
        begin
            if (hold_cnt[m] != 0)
            begin
                r.status     = ST_ERROR;
                r.lock_count = LCNT_W'(hold_cnt[m]);
            end
            else
            begin
                if (free_cnt < NUM_MUTEXES)
                begin
                    free_ids[(free_head + free_cnt) % NUM_MUTEXES] = m;
                    free_cnt++;
                end
                clear_entry(m);
            end
        end
        else if (op == OP_LOCK)
        begin
            if (hold_cnt[m] == 0)
            begin
                has_owner[m] = 1'b1;
                owner_of[m]  = pid;
                hold_cnt[m]  = 1;
                r.lock_count = LCNT_W'(1);
            end
            else if (wait_cnt[m] >= WAIT_DEPTH)
            begin
                r.status     = ST_ERROR;
                r.lock_count = LCNT_W'(hold_cnt[m]);
            end
            else
            begin
                slot = (wait_head[m] + wait_cnt[m]) % WAIT_DEPTH;
                waiters[m][slot] = pid;
                wait_cnt[m]++;
                hold_cnt[m]++;
                r.status     = ST_BLOCKED;
                r.lock_count = LCNT_W'(hold_cnt[m]);
            end
        end
        else
        begin
            if (hold_cnt[m] == 0)
            begin
                r.lock_count = '0;
            end
            else if (!has_owner[m] || owner_of[m] != pid)
            begin
                r.status     = ST_ERROR;
                r.lock_count = LCNT_W'(hold_cnt[m]);
            end
            else
            begin
                hold_cnt[m]--;
                if (wait_cnt[m] != 0)
                begin
                    slot         = wait_head[m];
                    r.wake_pid   = waiters[m][slot];
                    r.wake_valid = 1'b1;
                    wait_head[m] = (slot + 1) % WAIT_DEPTH;
                    wait_cnt[m]--;
                    owner_of[m]  = r.wake_pid;
                    has_owner[m] = 1'b1;
                end
                else
                begin
                    has_owner[m] = 1'b0;
                    owner_of[m]  = '0;
                end
                r.lock_count = LCNT_W'(hold_cnt[m]);
            end
        end
        return r;
    endfunction

    // Random allocated mutex, optionally only held ones or only idle ones; -1 if none.
    function automatic int pick_mutex(bit need_held, bit need_idle);
        int cands[$];
        int i;
        for (i = 0; i < NUM_MUTEXES; i++)
        begin
            if (is_alloc[i] && (!need_held || hold_cnt[i] != 0)
                && (!need_idle || hold_cnt[i] == 0))
            begin
                cands.push_back(i);
            end
        end
        if (cands.size() == 0)
        begin
            return -1;
        end
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Command driver: called at a rising edge, returns at the accept edge
    // (or after the idle gap that follows it). start stays high between
    // back-to-back items so it is never lowered and raised in one step.
    // ------------------------------------------------------------------

    task automatic send_cmd(op_t op, logic [ID_W-1:0] id, logic [PID_W-1:0] pid);
        int gap;
        start      <= 1'b1;
        opcode     <= op;
        mutex_id   <= id;
        caller_pid <= pid;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        pending_replies.push_back(apply_mutex_op(op, id, pid));
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the edge
    // that ends its cycle.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: status %0d result_id %0d lock_count %0d",
                       status, result_id, lock_count);
                mismatch_count++;
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (status !== oldest_reply.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_reply.status, status);
                    mismatch_count++;
                end
                if (result_id !== oldest_reply.result_id)
                begin
                    $error("result_id: expected %0d, got %0d",
                           oldest_reply.result_id, result_id);
                    mismatch_count++;
                end
                if (lock_count !== oldest_reply.lock_count)
                begin
                    $error("lock_count: expected %0d, got %0d",
                           oldest_reply.lock_count, lock_count);
                    mismatch_count++;
                end
                if (wake_valid !== oldest_reply.wake_valid)
                begin
                    $error("wake_valid: expected %0d, got %0d",
                           oldest_reply.wake_valid, wake_valid);
                    mismatch_count++;
                end
                if (wake_pid !== oldest_reply.wake_pid)
                begin
                    $error("wake_pid: expected %0d, got %0d",
                           oldest_reply.wake_pid, wake_pid);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detection: any accept or result restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walks one mutex through its life: errors on a never-allocated id,
    // self-lock, wrong-owner unlock, destroy while held, hand-over chain.
    task automatic test_basic_ops();
        int m;
        idle_pct = 0;
        send_cmd(OP_UNLOCK, 4'hF, 8'hFF);
        send_cmd(OP_DESTROY, 4'hF, 8'h00);
        send_cmd(OP_LOCK, 4'hF, 8'h00);
        m = free_ids[free_head];
        send_cmd(OP_ALLOC, 4'hF, 8'hFF);         // mutex_id is ignored here
        send_cmd(OP_UNLOCK, ID_W'(m), 8'h5A);    // count zero: plain done
        send_cmd(OP_LOCK, ID_W'(m), 8'h00);
        send_cmd(OP_LOCK, ID_W'(m), 8'hFF);
        send_cmd(OP_LOCK, ID_W'(m), 8'h00);      // owner queues behind itself
        send_cmd(OP_UNLOCK, ID_W'(m), 8'hAA);    // not the owner
        send_cmd(OP_DESTROY, ID_W'(m), 8'h00);   // still held
        send_cmd(OP_UNLOCK, ID_W'(m), 8'h00);    // hands over to 0xFF
        send_cmd(OP_UNLOCK, ID_W'(m), 8'hFF);    // hands back to 0x00
        send_cmd(OP_UNLOCK, ID_W'(m), 8'h00);    // no waiter left
        send_cmd(OP_DESTROY, ID_W'(m), 8'h00);
        send_cmd(OP_DESTROY, ID_W'(m), 8'h00);   // already gone
        send_cmd(OP_LOCK, ID_W'(m), 8'h33);
        send_cmd(OP_ALLOC, 4'h0, 8'h00);
    endtask

    // Drains the free id FIFO, allocates once more on empty, then returns
    // half the ids so the FIFO wraps on later allocates.
    task automatic test_id_exhaustion();
        int i;
        idle_pct = 20;
        while (free_cnt > 0)
        begin
            send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
        end
        send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
        for (i = NUM_MUTEXES - 1; i >= 0; i -= 2)
        begin
            if (is_alloc[i] && hold_cnt[i] == 0)
            begin
                send_cmd(OP_DESTROY, ID_W'(i), PID_W'($urandom));
            end
        end
        send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
        send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
    endtask

    // Fills one wait queue to the brim, overflows it, drains it through the
    // owner hand-over chain and destroys the mutex.
    task automatic test_queue_overflow();
        int m;
        int k;
        m = pick_mutex(1'b0, 1'b1);
        if (m < 0)
        begin
            if (free_cnt == 0)
            begin
                return;
            end
            m = free_ids[free_head];
            send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
        end
        for (k = 0; k <= WAIT_DEPTH; k++)
        begin
            send_cmd(OP_LOCK, ID_W'(m), PID_W'($urandom));
        end
        send_cmd(OP_LOCK, ID_W'(m), PID_W'($urandom));       // queue full
        for (k = 0; k <= WAIT_DEPTH; k++)
        begin
            send_cmd(OP_UNLOCK, ID_W'(m), owner_of[m]);
        end
        send_cmd(OP_UNLOCK, ID_W'(m), PID_W'($urandom));     // count zero
        send_cmd(OP_DESTROY, ID_W'(m), PID_W'($urandom));
    endtask

    // Mostly well-formed traffic on live mutexes, with a share of
    // wrong-owner unlocks and fully random commands as noise.
    task automatic test_random_mix(int count, int pct);
        int n;
        int sel;
        int m;
        idle_pct = pct;
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 7)
            begin
                send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
            end
            else if (sel < 13)
            begin
                m = pick_mutex(1'b0, 1'b1);
                if (m < 0)
                begin
                    m = pick_mutex(1'b0, 1'b0);
                end
                if (m < 0)
                begin
                    m = $urandom_range(0, NUM_MUTEXES - 1);
                end
                send_cmd(OP_DESTROY, ID_W'(m), PID_W'($urandom));
            end
            else if (sel < 50)
            begin
                m = pick_mutex(1'b0, 1'b0);
                if (m < 0)
                begin
                    send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
                end
                else
                begin
                    send_cmd(OP_LOCK, ID_W'(m), PID_W'($urandom));
                end
            end
            else if (sel < 85)
            begin
                m = pick_mutex(1'b1, 1'b0);
                if (m >= 0)
                begin
                    send_cmd(OP_UNLOCK, ID_W'(m), owner_of[m]);
                end
                else
                begin
                    m = pick_mutex(1'b0, 1'b0);
                    if (m < 0)
                    begin
                        send_cmd(OP_ALLOC, ID_W'($urandom), PID_W'($urandom));
                    end
                    else
                    begin
                        send_cmd(OP_LOCK, ID_W'(m), PID_W'($urandom));
                    end
                end
            end
            else if (sel < 92)
            begin
                m = pick_mutex(1'b1, 1'b0);
                if (m < 0)
                begin
                    m = $urandom_range(0, NUM_MUTEXES - 1);
                end
                send_cmd(OP_UNLOCK, ID_W'(m), PID_W'($urandom));
            end
            else
            begin
                send_cmd(op_t'($urandom_range(0, 3)), ID_W'($urandom), PID_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_id_exhaustion();
        test_queue_overflow();
        test_random_mix(170, 0);
        test_queue_overflow();
        test_random_mix(170, 56);
        test_random_mix(170, 0);
        test_queue_overflow();
        test_random_mix(170, 37);

        start <= 1'b0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
